FILE: hdl/esc_pkg.sv
package esc_pkg;

   // Seconds bias: 24856 days, a whole number of days above 2^31, keeps the sum positive.
   localparam logic [32:0] DAY_BIAS_SECS = 33'd2147558400;

   // 86400 = 128 * 675; quotient by 675 through a reciprocal, exact for 26-bit operands.
   localparam logic [26:0] RECIP_675 = 27'd101806633;
   localparam int unsigned RECIP_675_SHIFT = 36;
   localparam logic [9:0] DIV_675 = 10'd675;

   // Biased day count plus this is a multiple of 1461 at the epoch (18 * 1461).
   localparam logic [15:0] CYCLE_BIAS = 16'd1442;
   localparam logic [16:0] RECIP_1461 = 17'd91868;
   localparam int unsigned RECIP_1461_SHIFT = 27;
   localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;

   // Biased day count plus one is a multiple of 7 on a Saturday.
   localparam logic [15:0] WEEKDAY_BIAS = 16'd1;
   localparam logic [16:0] RECIP_7 = 17'd74899;
   localparam int unsigned RECIP_7_SHIFT = 19;
   localparam logic [2:0] DAYS_PER_WEEK = 3'd7;

   // Divide by 60, once for seconds of day, once for minutes of day.
   localparam logic [17:0] RECIP_60_SOD = 18'd139811;
   localparam int unsigned RECIP_60_SOD_SHIFT = 23;
   localparam logic [11:0] RECIP_60_MIN = 12'd2185;
   localparam int unsigned RECIP_60_MIN_SHIFT = 17;
   localparam logic [5:0] SIXTY = 6'd60;

   // Year of cycle index zero: 2000 - 4 * 18.
   localparam logic [10:0] YEAR_BASE = 11'd1928;

   // First day of the second, third and fourth year in a cycle.
   localparam logic [10:0] YEAR1_START = 11'd366;
   localparam logic [10:0] YEAR2_START = 11'd731;
   localparam logic [10:0] YEAR3_START = 11'd1096;

   localparam logic [8:0] CUM_COMMON [13] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };
   localparam logic [8:0] CUM_LEAP [13] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
   };

   // Days before the first of month idx (0 = January).
   function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
      logic [8:0] val;
      if (idx > 4'd12) begin
         val = 9'd0;
      end else if (leap) begin
         val = CUM_LEAP[idx];
      end else begin
         val = CUM_COMMON[idx];
      end
      return val;
   endfunction

   typedef struct packed {
      logic [15:0] day_biased;   // day count + 24856
      logic [16:0] sod;          // seconds of day
   } esc_day_type;

   typedef struct packed {
      logic [10:0] day_of_cycle;
      logic [5:0]  cycle;
      logic [2:0]  weekday;
      logic [5:0]  second;
      logic [4:0]  hour;
      logic [10:0] minute_of_day;
   } esc_div_type;

   typedef struct packed {
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [8:0]  day_of_year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } esc_rsp_type;

endpackage

FILE: hdl/esc_day_split.sv
// Seconds to (biased day, second of day): bias, reciprocal multiply, remainder.
module esc_day_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [31:0]  in_seconds,
   output logic                out_valid,
   input  logic                out_ready,
   output esc_pkg::esc_day_type out_day
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   logic [32:0] biased;
   logic [25:0] s1_hi_ff;
   logic [6:0]  s1_lo_ff;

   logic [52:0] s2_prod;
   logic [15:0] s2_quot_in, s2_quot_ff;
   logic [25:0] s2_hi_ff;
   logic [6:0]  s2_lo_ff;

   logic [25:0] s3_back;
   logic [25:0] s3_rem;
   esc_pkg::esc_day_type s3_day_in, s3_day_ff;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1: make the count positive, split off the power-of-two part of 86400
   assign biased = {in_seconds[31], in_seconds} + esc_pkg::DAY_BIAS_SECS;

   // stage 2: quotient by 675
   assign s2_prod    = 53'(s1_hi_ff) * 53'(esc_pkg::RECIP_675);
   assign s2_quot_in = s2_prod[esc_pkg::RECIP_675_SHIFT +: 16];

   // stage 3: remainder by 675, rejoin low bits
   assign s3_back = 26'(s2_quot_ff) * 26'(esc_pkg::DIV_675);
   assign s3_rem  = s2_hi_ff - s3_back;
   assign s3_day_in.day_biased = s2_quot_ff;
   assign s3_day_in.sod        = {s3_rem[9:0], s2_lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_hi_ff <= biased[32:7];
         s1_lo_ff <= biased[6:0];
      end
      if (s2_ready) begin
         s2_quot_ff <= s2_quot_in;
         s2_hi_ff   <= s1_hi_ff;
         s2_lo_ff   <= s1_lo_ff;
      end
      if (s3_ready) begin
         s3_day_ff <= s3_day_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_day   = s3_day_ff;

endmodule

FILE: hdl/esc_field_div.sv
// Day count into cycle/day-of-cycle and weekday; second of day into h/m/s parts.
module esc_field_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  esc_pkg::esc_day_type in_day,
   output logic                 out_valid,
   input  logic                 out_ready,
   output esc_pkg::esc_div_type out_div
);

   logic s4_valid_ff, s5_valid_ff;
   logic s4_ready, s5_ready;

   logic [15:0] cyc_num;
   logic [15:0] wk_num;
   logic [32:0] cyc_prod;
   logic [32:0] wk_prod;
   logic [34:0] min_prod;

   logic [15:0] s4_cyc_num_ff;
   logic [5:0]  s4_cycle_ff;
   logic [15:0] s4_wk_num_ff;
   logic [12:0] s4_wk_quot_ff;
   logic [16:0] s4_sod_ff;
   logic [10:0] s4_tm_ff;

   logic [15:0] cyc_back, dc_full;
   logic [15:0] wk_back, wd_full;
   logic [16:0] sec_back, sec_full;
   logic [22:0] hour_prod;
   esc_pkg::esc_div_type s5_div_in, s5_div_ff;

   assign s5_ready = !s5_valid_ff || out_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign in_ready = s4_ready;

   // stage 4: three reciprocal quotients
   assign cyc_num  = in_day.day_biased + esc_pkg::CYCLE_BIAS;
   assign wk_num   = in_day.day_biased + esc_pkg::WEEKDAY_BIAS;
   assign cyc_prod = 33'(cyc_num) * 33'(esc_pkg::RECIP_1461);
   assign wk_prod  = 33'(wk_num) * 33'(esc_pkg::RECIP_7);
   assign min_prod = 35'(in_day.sod) * 35'(esc_pkg::RECIP_60_SOD);

   // stage 5: remainders, hour quotient
   assign cyc_back  = 16'(s4_cycle_ff) * 16'(esc_pkg::DAYS_PER_CYCLE);
   assign dc_full   = s4_cyc_num_ff - cyc_back;
   assign wk_back   = 16'(s4_wk_quot_ff) * 16'(esc_pkg::DAYS_PER_WEEK);
   assign wd_full   = s4_wk_num_ff - wk_back;
   assign sec_back  = 17'(s4_tm_ff) * 17'(esc_pkg::SIXTY);
   assign sec_full  = s4_sod_ff - sec_back;
   assign hour_prod = 23'(s4_tm_ff) * 23'(esc_pkg::RECIP_60_MIN);

   assign s5_div_in.day_of_cycle  = dc_full[10:0];
   assign s5_div_in.cycle         = s4_cycle_ff;
   assign s5_div_in.weekday       = wd_full[2:0];
   assign s5_div_in.second        = sec_full[5:0];
   assign s5_div_in.hour          = hour_prod[esc_pkg::RECIP_60_MIN_SHIFT +: 5];
   assign s5_div_in.minute_of_day = s4_tm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s4_ready) s4_valid_ff <= in_valid;
         if (s5_ready) s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_cyc_num_ff <= cyc_num;
         s4_cycle_ff   <= cyc_prod[esc_pkg::RECIP_1461_SHIFT +: 6];
         s4_wk_num_ff  <= wk_num;
         s4_wk_quot_ff <= wk_prod[esc_pkg::RECIP_7_SHIFT +: 13];
         s4_sod_ff     <= in_day.sod;
         s4_tm_ff      <= min_prod[esc_pkg::RECIP_60_SOD_SHIFT +: 11];
      end
      if (s5_ready) begin
         s5_div_ff <= s5_div_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_div   = s5_div_ff;

endmodule

FILE: hdl/esc_calendar.sv
// Year within the cycle, minute, then month lookup into the output register.
module esc_calendar (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  esc_pkg::esc_div_type in_div,
   output logic                 out_valid,
   input  logic                 out_ready,
   output esc_pkg::esc_rsp_type out_rsp
);

   logic s6_valid_ff, s7_valid_ff;
   logic s6_ready, s7_ready;

   logic [1:0]  yoff;
   logic [10:0] ystart;
   logic [10:0] yday_full;
   logic [10:0] min_back, min_full;

   logic [8:0]  s6_yday_ff;
   logic        s6_leap_ff;
   logic [10:0] s6_year_ff;
   logic [2:0]  s6_weekday_ff;
   logic [5:0]  s6_second_ff;
   logic [4:0]  s6_hour_ff;
   logic [5:0]  s6_minute_ff;

   logic [3:0]  month_idx;
   logic [8:0]  mday_full;
   esc_pkg::esc_rsp_type s7_rsp_in, s7_rsp_ff;

   assign s7_ready = !s7_valid_ff || out_ready;
   assign s6_ready = !s6_valid_ff || s7_ready;
   assign in_ready = s6_ready;

   // stage 6: year of the cycle; first year of each cycle is the leap year
   always_comb begin
      priority if (in_div.day_of_cycle < esc_pkg::YEAR1_START) begin
         yoff   = 2'd0;
         ystart = 11'd0;
      end else if (in_div.day_of_cycle < esc_pkg::YEAR2_START) begin
         yoff   = 2'd1;
         ystart = esc_pkg::YEAR1_START;
      end else if (in_div.day_of_cycle < esc_pkg::YEAR3_START) begin
         yoff   = 2'd2;
         ystart = esc_pkg::YEAR2_START;
      end else begin
         yoff   = 2'd3;
         ystart = esc_pkg::YEAR3_START;
      end
   end

   assign yday_full = in_div.day_of_cycle - ystart + 11'd1;
   assign min_back  = 11'(in_div.hour) * 11'(esc_pkg::SIXTY);
   assign min_full  = in_div.minute_of_day - min_back;

   // stage 7: month from the cumulative table; compares are independent
   always_comb begin
      month_idx = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (s6_yday_ff > esc_pkg::month_start(s6_leap_ff, 4'(k))) month_idx = 4'(k);
      end
      mday_full = s6_yday_ff - esc_pkg::month_start(s6_leap_ff, month_idx);
   end

   assign s7_rsp_in.year         = s6_year_ff;
   assign s7_rsp_in.month        = month_idx + 4'd1;
   assign s7_rsp_in.day_of_month = mday_full[4:0];
   assign s7_rsp_in.day_of_year  = s6_yday_ff;
   assign s7_rsp_in.hour         = s6_hour_ff;
   assign s7_rsp_in.minute       = s6_minute_ff;
   assign s7_rsp_in.second       = s6_second_ff;
   assign s7_rsp_in.weekday      = s6_weekday_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         if (s6_ready) s6_valid_ff <= in_valid;
         if (s7_ready) s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s6_ready) begin
         s6_yday_ff    <= yday_full[8:0];
         s6_leap_ff    <= (yoff == 2'd0);
         // year wraps at 11 bits, same as the field
         s6_year_ff    <= esc_pkg::YEAR_BASE + {3'd0, in_div.cycle, 2'd0} + {9'd0, yoff};
         s6_weekday_ff <= in_div.weekday;
         s6_second_ff  <= in_div.second;
         s6_hour_ff    <= in_div.hour;
         s6_minute_ff  <= min_full[5:0];
      end
      if (s7_ready) begin
         s7_rsp_ff <= s7_rsp_in;
      end
   end

   assign out_valid = s7_valid_ff;
   assign out_rsp   = s7_rsp_ff;

endmodule

FILE: hdl/epoch_seconds_to_calendar.sv
// Pipeline: seven register stages from an accepted req beat to rsp_valid.
// Throughput: one beat per cycle while rsp_stall stays low; every stage is a register with its own valid bit.
// Stall: a stage holds only while it is full and the stage after it cannot take data,
//   so req beats keep entering while empty slots remain behind a stalled rsp beat.
// Reset: synchronous, active high; clears the valid bits, data registers keep contents.
module epoch_seconds_to_calendar (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_seconds_since_epoch,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [10:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day_of_month,
   output logic [8:0]         rsp_day_of_year,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second,
   output logic [2:0]         rsp_weekday
);

   // Stages 1-3: seconds biased positive, split into day count and second of day
   // by a shift (128) and a reciprocal multiply (675).
   // Stages 4-5: day count into 1461-day cycles and weekday, second of day into
   // hour, minute of day and second, all by reciprocal multiply and back-subtract.
   // Stages 6-7: year within the cycle, minute, month search, output register.

   logic                 day_valid, day_ready;
   esc_pkg::esc_day_type day_beat;
   logic                 div_valid, div_ready;
   esc_pkg::esc_div_type div_beat;
   logic                 req_ready;
   esc_pkg::esc_rsp_type rsp_beat;

   esc_day_split u_day_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_seconds (req_seconds_since_epoch),
      .out_valid  (day_valid),
      .out_ready  (day_ready),
      .out_day    (day_beat)
   );

   esc_field_div u_field_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (day_valid),
      .in_ready  (day_ready),
      .in_day    (day_beat),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_div   (div_beat)
   );

   esc_calendar u_calendar (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_div    (div_beat),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_rsp   (rsp_beat)
   );

   // stall only reaches the input once every stage holds a beat
   assign req_stall = !req_ready;

   assign rsp_year         = rsp_beat.year;
   assign rsp_month        = rsp_beat.month;
   assign rsp_day_of_month = rsp_beat.day_of_month;
   assign rsp_day_of_year  = rsp_beat.day_of_year;
   assign rsp_hour         = rsp_beat.hour;
   assign rsp_minute       = rsp_beat.minute;
   assign rsp_second       = rsp_beat.second;
   assign rsp_weekday      = rsp_beat.weekday;

endmodule

FILE: hdl/esc_checker.sv
module esc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic signed [31:0] req_seconds_since_epoch,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [10:0]        rsp_year,
   input logic [3:0]         rsp_month,
   input logic [4:0]         rsp_day_of_month,
   input logic [8:0]         rsp_day_of_year,
   input logic [4:0]         rsp_hour,
   input logic [5:0]         rsp_minute,
   input logic [5:0]         rsp_second,
   input logic [2:0]         rsp_weekday
);

   // a stalled req beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_seconds_since_epoch))
      else $error("req beat changed under stall");

   // a stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_year) && $stable(rsp_month)
         && $stable(rsp_day_of_month) && $stable(rsp_day_of_year) && $stable(rsp_hour)
         && $stable(rsp_minute) && $stable(rsp_second) && $stable(rsp_weekday))
      else $error("rsp beat changed under stall");

   // with the output slot free, every stage can move, so the input never stalls
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled while output empty");

   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day_of_month >= 5'd1
         && rsp_day_of_year >= 9'd1 && rsp_day_of_year <= 9'd366 && rsp_hour <= 5'd23
         && rsp_minute <= 6'd59 && rsp_second <= 6'd59 && rsp_weekday <= 3'd6)
      else $error("rsp field out of range");

   // January: day of year and day of month agree
   a_january: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_month == 4'd1 |-> rsp_day_of_year == {4'd0, rsp_day_of_month})
      else $error("January day mismatch");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);

FILE: tb/sv/testbench.sv
module testbench;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request side, driven at the falling edge
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_seconds_since_epoch = '0;

   // Result side
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [10:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [8:0]  rsp_day_of_year;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic [2:0]  rsp_weekday;

   // Timestamps waiting to be sent, and dates waiting to come back
   logic signed [31:0]   pending_seconds [$];
   esc_pkg::esc_rsp_type expected_dates [$];

   int unsigned beats_sent = 0;  // items handed to the request port
   bit          req_taken = 1'b0; // request beat accepted at the last rising edge
   bit          failed = 1'b0;
   esc_pkg::esc_rsp_type want;

   epoch_seconds_to_calendar i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_seconds_since_epoch (req_seconds_since_epoch),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_year                (rsp_year),
      .rsp_month               (rsp_month),
      .rsp_day_of_month        (rsp_day_of_month),
      .rsp_day_of_year         (rsp_day_of_year),
      .rsp_hour                (rsp_hour),
      .rsp_minute              (rsp_minute),
      .rsp_second              (rsp_second),
      .rsp_weekday             (rsp_weekday)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Expected calendar date for a signed second count from 2000-01-01 00:00:00.
   // Days and seconds of day come from floor division so negative counts land on
   // the previous day with a positive time of day. Days then split into 1461-day
   // cycles, each starting with a leap year (true for 1931..2068).
   function automatic esc_pkg::esc_rsp_type calendar_of_seconds(
      input logic signed [31:0] secs);
      esc_pkg::esc_rsp_type d;
      longint total, days, sod, cyc, dc, yday, wd, yoff, ystart;
      int     mon, len;
      int     mlen [12];
      total = secs;
      days = total / 86400;
      if (total % 86400 < 0) begin
         days = days - 1;
      end
      sod = total - days * 86400;
      wd = days % 7;
      if (wd < 0) begin
         wd = wd + 7;
      end
      cyc = days / 1461;
      if (days % 1461 < 0) begin
         cyc = cyc - 1;
      end
      dc = days - cyc * 1461;
      if (dc < 366) begin
         yoff = 0; ystart = 0;
      end else if (dc < 731) begin
         yoff = 1; ystart = 366;
      end else if (dc < 1096) begin
         yoff = 2; ystart = 731;
      end else begin
         yoff = 3; ystart = 1096;
      end
      yday = dc - ystart + 1;
      mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (yoff == 0) begin
         mlen[1] = 29;
      end
      // walk the months down to the day within the month
      total = yday;
      mon = 0;
      len = mlen[0];
      while (mon < 11 && total > len) begin
         total = total - len;
         mon = mon + 1;
         len = mlen[mon];
      end
      d.year         = 11'(2000 + 4 * cyc + yoff);
      d.month        = 4'(mon + 1);
      d.day_of_month = 5'(total);
      d.day_of_year  = 9'(yday);
      d.hour         = 5'(sod / 3600);
      d.minute       = 6'((sod / 60) % 60);
      d.second       = 6'(sod % 60);
      d.weekday      = 3'(wd);
      return d;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         failed = 1'b1;
      end
   endtask

   // Quiet window: no random idles or stalls on either side while these items go through.
   function automatic bit quiet_window();
      return beats_sent >= 500 && beats_sent < 700;
   endfunction

   // Request driver. A beat stays on the port until it is taken; a new one is
   // loaded only after acceptance. Every 300 items the sender holds off until
   // all outstanding dates have come back, so the pipe fully drains.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_seconds.size() == 0 ||
             (beats_sent > 0 && beats_sent % 300 == 0 && expected_dates.size() != 0) ||
             (!quiet_window() && $urandom_range(0, 99) < 28)) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_seconds_since_epoch <= pending_seconds.pop_front();
            beats_sent = beats_sent + 1;
         end
      end
   end

   // Result stall, random outside the quiet window
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet_window() && $urandom_range(0, 99) < 28;
      end
   end

   // Monitor: predicts on every accepted request beat, checks every accepted
   // result beat against the oldest prediction.
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         expected_dates.push_back(calendar_of_seconds(req_seconds_since_epoch));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dates.size() == 0) begin
            $error("result beat with no date outstanding");
            failed = 1'b1;
         end else begin
            want = expected_dates.pop_front();
            check_field("year", 32'(want.year), 32'(rsp_year));
            check_field("month", 32'(want.month), 32'(rsp_month));
            check_field("day_of_month", 32'(want.day_of_month), 32'(rsp_day_of_month));
            check_field("day_of_year", 32'(want.day_of_year), 32'(rsp_day_of_year));
            check_field("hour", 32'(want.hour), 32'(rsp_hour));
            check_field("minute", 32'(want.minute), 32'(rsp_minute));
            check_field("second", 32'(want.second), 32'(rsp_second));
            check_field("weekday", 32'(want.weekday), 32'(rsp_weekday));
         end
      end
   end

   // Stimulus and end of run
   initial begin
      longint day_no;
      int     pick;
      int     ystarts [4];
      ystarts = '{0, 366, 731, 1096};

      // Directed: epoch, one second either side, range ends, day edges,
      // leap days, year and cycle edges, alternating bit patterns.
      pending_seconds.push_back(32'sd0);
      pending_seconds.push_back(-32'sd1);           // 1999-12-31 23:59:59, Friday
      pending_seconds.push_back(32'sd1);
      pending_seconds.push_back(32'sh7fffffff);     // 2068-01-19
      pending_seconds.push_back(32'sh80000000);     // 1931-12-13
      pending_seconds.push_back(32'sd86399);
      pending_seconds.push_back(32'sd86400);
      pending_seconds.push_back(-32'sd86400);
      pending_seconds.push_back(-32'sd86401);
      pending_seconds.push_back(32'sd5097600);      // 2000-02-29
      pending_seconds.push_back(32'sd5184000);      // 2000-03-01
      pending_seconds.push_back(32'(365 * 86400 + 86399)); // 2000-12-31 last second
      pending_seconds.push_back(32'(366 * 86400));  // 2001-01-01
      pending_seconds.push_back(32'sd131328000);    // 2004-02-29
      pending_seconds.push_back(32'sd126230400);    // one full cycle
      pending_seconds.push_back(-32'sd126230400);
      pending_seconds.push_back(32'(-306 * 86400)); // 1999-03-01
      pending_seconds.push_back(32'(-307 * 86400)); // 1999-02-28
      pending_seconds.push_back(32'(12 * 3600 + 34 * 60 + 56));
      pending_seconds.push_back(32'sh55555555);
      pending_seconds.push_back(32'shaaaaaaaa);
      pending_seconds.push_back(32'sh7fffff80);
      pending_seconds.push_back(32'sh80000001);

      // Random: raw words, day edges, and year or leap-day edges.
      for (int k = 0; k < 1200; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            pending_seconds.push_back($urandom);
         end else if (pick < 75) begin
            day_no = longint'($urandom_range(0, 49710)) - 24855;
            pending_seconds.push_back(32'(day_no * 86400 + int'($urandom_range(0, 4)) - 2));
         end else begin
            day_no = (longint'($urandom_range(0, 34)) - 18) * 1461
                     + ystarts[$urandom_range(0, 3)];
            if ($urandom_range(0, 1) != 0) begin
               day_no = day_no + int'($urandom_range(0, 2)) - 1;
            end else begin
               day_no = day_no + 58 + int'($urandom_range(0, 2));
            end
            pending_seconds.push_back(32'(day_no * 86400 +
                                          ($urandom_range(0, 1) != 0 ? 0 : 86399)));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all stimulus accepted, then everything returned, then a latency margin
      while (pending_seconds.size() != 0 || req_valid) @(posedge clock);
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_dates.size() != 0) begin
         $error("%0d dates never came back", expected_dates.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("testbench failed");
      $finish;
   end

endmodule
